// ===== hw/rtl/pps_pkg.sv =====
package pps_pkg;

	localparam int TASK_SLOTS   = 16;
	localparam int CPU_COUNT    = 8;
	localparam int POINTS_WIDTH = 8;

	localparam int SLOT_W = $clog2(TASK_SLOTS);
	localparam int CPU_W  = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
	localparam int CMP_W  = (POINTS_WIDTH > 8) ? POINTS_WIDTH : 8;

	localparam logic [CMP_W-1:0] PTS_MAX = CMP_W'((1 << POINTS_WIDTH) - 1);

	localparam logic [1:0] OP_CREATE = 2'd0;
	localparam logic [1:0] OP_BLOCK  = 2'd1;
	localparam logic [1:0] OP_END    = 2'd2;
	localparam logic [1:0] OP_SWITCH = 2'd3;

	localparam logic [1:0] G_RT     = 2'd0;
	localparam logic [1:0] G_NORMAL = 2'd1;
	localparam logic [1:0] G_LOW    = 2'd2;
	localparam logic [1:0] G_IDLE   = 2'd3;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_FULL    = 3'd1;
	localparam logic [2:0] ST_NO_TASK = 3'd2;
	localparam logic [2:0] ST_NO_CUR  = 3'd3;
	localparam logic [2:0] ST_ENDING  = 3'd4;

	typedef enum logic [3:0] {
		CO_NONE, CO_CREATE, CO_BLOCK, CO_END, CO_UNQUAR,
		CO_DEC, CO_INC, CO_DESCHED, CO_SCHED, CO_FREE
	} cell_op_t;

	typedef struct packed {
		logic [1:0]       group;
		logic [CPU_W-1:0] cpu;
		logic             pinned;
		logic             flag;
	} cell_bcast_t;

	typedef struct packed {
		logic                    valid;
		logic [1:0]              group;
		logic [CPU_W-1:0]        cpu;
		logic                    pinned;
		logic                    running;
		logic                    blocked;
		logic                    ended;
		logic                    quar;
		logic [POINTS_WIDTH-1:0] points;
	} task_rec_t;

endpackage

// ===== hw/rtl/pps_cell.sv =====
module pps_cell import pps_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cell_op_t    op,
	input  cell_bcast_t bc,
	output task_rec_t   rec
);

	task_rec_t rec_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q <= '0;
		end else begin
			unique case (op)
				CO_CREATE: begin
					// fresh task: unblocked, not ended, not quarantined, no points
					rec_q <= {1'b1, bc.group, bc.cpu, bc.pinned, bc.flag,
						1'b0, 1'b0, 1'b0, {POINTS_WIDTH{1'b0}}};
				end
				CO_BLOCK:   rec_q.blocked <= bc.flag;
				CO_END:     rec_q.ended   <= 1'b1;
				CO_UNQUAR:  rec_q.quar    <= 1'b0;
				CO_DEC: begin
					if (rec_q.points != '0) rec_q.points <= rec_q.points - 1'b1;
				end
				CO_INC:     rec_q.points  <= rec_q.points + 1'b1;
				CO_DESCHED: begin
					rec_q.running <= 1'b0;
					rec_q.quar    <= 1'b1;
				end
				CO_SCHED: begin
					rec_q.running <= 1'b1;
					rec_q.cpu     <= bc.cpu;
				end
				CO_FREE:    rec_q <= '0;
				default: ;
			endcase
		end
	end

	assign rec = rec_q;

endmodule

// ===== hw/rtl/priority_points_task_scheduler.sv =====
// Create, set blocked and mark ended pass from accept through one result step;
// a switch runs one table walk to pool, one pool step, one points step, one walk for
// the minimum, one commit step and one result step; a switch ending in no viable or
// no current task goes from the points step straight to the result step.
// Throughput: one item at a time; the next item is taken once the result is in
// the output register. arst_n clears every slot to invalid and the points ceiling to 16.
module priority_points_task_scheduler import pps_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic [3:0]  slot,
	input  logic [1:0]  group,
	input  logic [2:0]  cpu,
	input  logic        pinned,
	input  logic        flag_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [3:0]  chosen_slot,
	output logic        switched,
	output logic        freed,
	output logic [3:0]  previous_slot,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);

	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_POOL, S_POINTS, S_MIN, S_FINAL, S_DONE} state_t;

	state_t state_q;

	// row of slot cells
	task_rec_t   recs [TASK_SLOTS];
	cell_op_t    ops  [TASK_SLOTS];
	cell_bcast_t bc;

	for (genvar g = 0; g < TASK_SLOTS; g++) begin : g_cell
		pps_cell u_cell (.clk(clk), .arst_n(arst_n), .op(ops[g]), .bc(bc), .rec(recs[g]));
	end

	logic [7:0]            pts_ceiling_q;
	logic [CPU_W-1:0]      cpu_q;
	logic [SLOT_W-1:0]     idx_q, cur_q, win_q;
	logic                  curv_q, cur_ecur_q, winv_q;
	logic [1:0]            curg_q;
	logic [POINTS_WIDTH-1:0] winpts_q;
	logic [TASK_SLOTS-1:0] m0_q, m1_q, m2_q, m3_q, pool_q;
	logic [2:0]            st_q;
	logic [3:0]            ch_q, pv_q;
	logic                  sw_q, fr_q;
	logic                  out_valid_q;
	logic [2:0]            status_q;
	logic [3:0]            chosen_q, prev_q;
	logic                  switched_q, freed_q;

	logic [CPU_W-1:0] cpu_in;
	assign cpu_in = CPU_W'(cpu % CPU_COUNT);

	wire accept = in_valid && in_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;

	// lowest free slot
	logic              free_any;
	logic [SLOT_W-1:0] free_idx;
	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
			if (!recs[i].valid) begin
				free_any = 1'b1;
				free_idx = SLOT_W'(i);
			end
		end
	end

	logic slot_ok;
	assign slot_ok = ({1'b0, slot} < 5'(TASK_SLOTS)) && recs[SLOT_W'(slot)].valid;

	// eligibility of the slot under the scan pointer
	task_rec_t r;
	logic same, skip, quar_eff, iscur, base, e_cur, e_nocur;
	always_comb begin
		r        = recs[idx_q];
		same     = (r.cpu == cpu_q);
		skip     = !r.valid || (r.pinned && !same);
		quar_eff = same ? 1'b0 : r.quar;
		iscur    = same && !r.quar && r.running;
		base     = !r.blocked && !r.ended && !quar_eff;
		e_cur    = base && (iscur || !r.running);
		e_nocur  = base && !r.running;
	end

	// pool: realtime, else normal, else low, else idle
	logic [TASK_SLOTS-1:0] m2f, m3f, pool_d;
	always_comb begin
		m2f = m2_q;
		m3f = m3_q;
		if (curv_q) begin
			m2f[cur_q] = (curg_q == G_LOW)  && cur_ecur_q;
			m3f[cur_q] = (curg_q == G_IDLE) && cur_ecur_q;
		end
		if (|m0_q)      pool_d = m0_q;
		else if (|m1_q) pool_d = m1_q;
		else if (|m2f)  pool_d = m2f;
		else            pool_d = m3f;
	end

	// ceiling check on the current task
	task_rec_t c;
	logic [CMP_W-1:0] ceil_v;
	logic at_ceil;
	always_comb begin
		c       = recs[cur_q];
		ceil_v  = (CMP_W'(pts_ceiling_q) < PTS_MAX) ? CMP_W'(pts_ceiling_q) : PTS_MAX;
		at_ceil = CMP_W'(c.points) >= ceil_v;
	end

	// cell commands
	always_comb begin
		for (int i = 0; i < TASK_SLOTS; i++) ops[i] = CO_NONE;
		bc.group  = group;
		bc.cpu    = (state_q == S_IDLE) ? cpu_in : cpu_q;
		bc.pinned = pinned;
		bc.flag   = flag_value;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (opcode)
						OP_CREATE: if (free_any) ops[free_idx] = CO_CREATE;
						OP_BLOCK:  if (slot_ok) ops[SLOT_W'(slot)] = CO_BLOCK;
						OP_END:    if (slot_ok) ops[SLOT_W'(slot)] = CO_END;
						default: ;
					endcase
				end
			end
			S_SCAN: if (r.valid && same && r.quar) ops[idx_q] = CO_UNQUAR;
			S_POINTS: begin
				if (|pool_q && curv_q) begin
					if (at_ceil) begin
						if (pool_q[cur_q]) begin
							for (int i = 0; i < TASK_SLOTS; i++)
								if (pool_q[i]) ops[i] = CO_DEC;
						end
					end else begin
						ops[cur_q] = CO_INC;
					end
				end
			end
			S_FINAL: begin
				if (win_q != cur_q) begin
					ops[cur_q] = c.ended ? CO_FREE : CO_DESCHED;
					ops[win_q] = CO_SCHED;
				end
			end
			default: ;
		endcase
	end

	wire last = (idx_q == SLOT_W'(TASK_SLOTS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			pts_ceiling_q <= 8'd16;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) pts_ceiling_q <= cfg_data;
			// drop the result once taken, unless a new one replaces it
			if (out_valid_q && out_ready && state_q != S_DONE) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						st_q <= (opcode == OP_CREATE && !free_any) ? ST_FULL : ST_OK;
						ch_q <= (opcode == OP_CREATE && free_any) ? 4'(free_idx) : 4'd0;
						sw_q <= 1'b0; fr_q <= 1'b0; pv_q <= '0;
						cpu_q <= cpu_in;
						idx_q <= '0;
						curv_q <= 1'b0;
						m0_q <= '0; m1_q <= '0; m2_q <= '0; m3_q <= '0;
						state_q <= (opcode == OP_SWITCH) ? S_SCAN : S_DONE;
					end
				end
				S_SCAN: begin
					if (iscur && r.valid) begin
						curv_q     <= 1'b1;
						cur_q      <= idx_q;
						curg_q     <= r.group;
						cur_ecur_q <= !r.blocked && !r.ended;
					end
					m0_q[idx_q] <= !skip && e_cur && (r.group == G_RT);
					m1_q[idx_q] <= !skip && e_cur && (r.group == G_NORMAL);
					m2_q[idx_q] <= !skip && e_nocur && (r.group == G_LOW);
					m3_q[idx_q] <= !skip && e_nocur && (r.group == G_IDLE);
					idx_q <= idx_q + 1'b1;
					if (last) state_q <= S_POOL;
				end
				S_POOL: begin
					pool_q  <= pool_d;
					state_q <= S_POINTS;
				end
				S_POINTS: begin
					pv_q   <= curv_q ? 4'(cur_q) : 4'd0;
					idx_q  <= '0;
					winv_q <= 1'b0;
					if (!(|pool_q)) begin
						st_q <= ST_NO_TASK; state_q <= S_DONE;
					end else if (!curv_q) begin
						st_q <= ST_NO_CUR; state_q <= S_DONE;
					end else begin
						state_q <= S_MIN;
					end
				end
				S_MIN: begin
					if (pool_q[idx_q] && (!winv_q || recs[idx_q].points < winpts_q)) begin
						winv_q   <= 1'b1;
						win_q    <= idx_q;
						winpts_q <= recs[idx_q].points;
					end
					idx_q <= idx_q + 1'b1;
					if (last) state_q <= S_FINAL;
				end
				S_FINAL: begin
					if (win_q != cur_q) begin
						ch_q <= 4'(win_q); sw_q <= 1'b1; fr_q <= c.ended;
					end else if (c.ended) begin
						st_q <= ST_ENDING;
					end else begin
						ch_q <= 4'(win_q);
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					// hold the result until the output register is free
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						status_q    <= st_q;
						chosen_q    <= ch_q;
						switched_q  <= sw_q;
						freed_q     <= fr_q;
						prev_q      <= pv_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign chosen_slot   = chosen_q;
	assign switched      = switched_q;
	assign freed         = freed_q;
	assign previous_slot = prev_q;

endmodule
